FILE: hw/rtl/ace_pkg.sv
// ----------------------------------------------------------------------------
// ace_pkg - shared types and constants of the arithmetic encoder core
// Sequencer states, the result record and a follow-count helper.
// ----------------------------------------------------------------------------
package ace_pkg;

	localparam int FOLLOW_BITS = 16;
	localparam logic [FOLLOW_BITS-1:0] FOLLOW_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HI_START,
		ST_HI_WAIT,
		ST_LO_START,
		ST_LO_WAIT,
		ST_RENORM,
		ST_FINISH,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic                   out_bit;
		logic [FOLLOW_BITS-1:0] follow_count;
		logic                   last;
		logic                   stream_end;
	} result_t;

	// saturating increment of the pending follow count
	function automatic logic [FOLLOW_BITS-1:0] follow_inc(input logic [FOLLOW_BITS-1:0] cnt);
		logic [FOLLOW_BITS-1:0] res;
		res = (cnt == FOLLOW_MAX) ? cnt : cnt + FOLLOW_BITS'(1);
		return res;
	endfunction

endpackage

FILE: hw/rtl/arithmetic_encoder_core.sv
// ----------------------------------------------------------------------------
// arithmetic_encoder_core - integer arithmetic encoder, CODE_BITS interval
// Narrows the low/high interval per symbol and renormalizes, emitting code
// bits with their pending follow counts.
// ----------------------------------------------------------------------------
// One item at a time: in_ready is high only while the sequencer is idle.
// After an item transfers in, its two interval scalings run in turn on the
// single shared multiply/restoring-divide unit, which produces one quotient
// bit per cycle. After that come the renormalization steps (at most
// CODE_BITS), the check that renormalization is done, the closing bit of a
// finish item and the flush of the final result. Results leave through a
// one-entry output register and a one-entry hold slot, so a slow consumer
// only stalls the sequencer when a held bit must be passed on to the output
// register. The hold slot delays each bit until the next one (or the end of
// the item) is known, which is how the final result of an item gets its
// last flag. A zero total is taken as one; counts are clamped so cum_low <=
// cum_high <= total, and an empty symbol collapses to a width-one interval.
// ----------------------------------------------------------------------------
module arithmetic_encoder_core #(
	parameter int CODE_BITS = 16,
	parameter int FREQ_BITS = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic [FREQ_BITS-1:0]                 cum_high,
	input  logic [FREQ_BITS-1:0]                 cum_low,
	input  logic [FREQ_BITS-1:0]                 total,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 out_bit,
	output logic [ace_pkg::FOLLOW_BITS-1:0]      follow_count,
	output logic                                 last,
	output logic                                 stream_end
);

	localparam int QW     = CODE_BITS + 1;
	localparam int STEP_W = $clog2(CODE_BITS + 1);

	ace_pkg::state_t state_q, state_d;

	// latched item
	logic                 kind_q;
	logic [FREQ_BITS-1:0] ch_q, cl_q, tot_q;
	logic [QW-1:0]        range_q;
	logic [QW-1:0]        qh_q;

	// coder state
	logic [CODE_BITS-1:0]            low_q, high_q;
	logic [ace_pkg::FOLLOW_BITS-1:0] pending_q;
	logic [STEP_W-1:0]               steps_q;

	// hold slot: newest emitted bit, waiting to learn if it is the last one
	logic             hold_valid_q;
	ace_pkg::result_t hold_q;

	// input clamps
	logic [FREQ_BITS-1:0] tot_c, ch_c, cl_c;

	// shared scale unit
	logic                 md_start;
	logic [FREQ_BITS-1:0] md_b;
	logic                 md_done;
	logic [QW-1:0]        md_quot;

	// narrowing
	logic [QW-1:0]        nl_w, nh_w, nh_m1;
	logic [CODE_BITS-1:0] low_narrow, high_narrow;

	// renormalization decision
	logic emit0, emit1, mid, renorm_stop;

	// sequencer controls
	logic             take_in, load_qh, load_narrow;
	logic             do_shift, do_mid, do_emit, do_finish, do_flush;
	logic             push;
	ace_pkg::result_t push_data;
	logic             out_free;

	assign tot_c = (total == '0) ? FREQ_BITS'(1) : total;
	assign ch_c  = (cum_high > tot_c) ? tot_c : cum_high;
	assign cl_c  = (cum_low > ch_c) ? ch_c : cum_low;

	assign md_b = (state_q == ace_pkg::ST_LO_START) ? cl_q : ch_q;

	ace_muldiv #(
		.QW(QW),
		.FW(FREQ_BITS)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (md_start),
		.a     (range_q),
		.b     (md_b),
		.div   (tot_q),
		.done  (md_done),
		.quot  (md_quot)
	);

	// new bounds; the top is one below low + range*cum_high/total
	assign nl_w        = {1'b0, low_q} + md_quot;
	assign nh_w        = {1'b0, low_q} + qh_q;
	assign nh_m1       = nh_w - QW'(1);
	assign low_narrow  = nl_w[CODE_BITS-1:0];
	assign high_narrow = (qh_q > md_quot) ? nh_m1[CODE_BITS-1:0] : nl_w[CODE_BITS-1:0];

	// lower half, upper half, middle quarter
	assign emit0       = !high_q[CODE_BITS-1];
	assign emit1       = low_q[CODE_BITS-1];
	assign mid         = !emit0 && !emit1 && (low_q[CODE_BITS-1 -: 2] == 2'b01)
	                     && (high_q[CODE_BITS-1 -: 2] == 2'b10);
	assign renorm_stop = (steps_q == STEP_W'(CODE_BITS)) || !(emit0 || emit1 || mid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ace_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		take_in     = 1'b0;
		md_start    = 1'b0;
		load_qh     = 1'b0;
		load_narrow = 1'b0;
		do_shift    = 1'b0;
		do_mid      = 1'b0;
		do_emit     = 1'b0;
		do_finish   = 1'b0;
		do_flush    = 1'b0;
		push        = 1'b0;
		push_data   = hold_q;
		case (state_q)
			ace_pkg::ST_IDLE: begin
				if (in_valid) begin
					take_in = 1'b1;
					state_d = ace_pkg::ST_HI_START;
				end
			end
			ace_pkg::ST_HI_START: begin
				md_start = 1'b1;
				state_d  = ace_pkg::ST_HI_WAIT;
			end
			ace_pkg::ST_HI_WAIT: begin
				if (md_done) begin
					load_qh = 1'b1;
					state_d = ace_pkg::ST_LO_START;
				end
			end
			ace_pkg::ST_LO_START: begin
				md_start = 1'b1;
				state_d  = ace_pkg::ST_LO_WAIT;
			end
			ace_pkg::ST_LO_WAIT: begin
				if (md_done) begin
					load_narrow = 1'b1;
					state_d     = ace_pkg::ST_RENORM;
				end
			end
			ace_pkg::ST_RENORM: begin
				if (renorm_stop) begin
					state_d = kind_q ? ace_pkg::ST_FINISH : ace_pkg::ST_FLUSH;
				end else if (mid) begin
					do_shift = 1'b1;
					do_mid   = 1'b1;
				end else if (!hold_valid_q || out_free) begin
					// pass the older bit on, keep the new one in the slot
					push           = hold_valid_q;
					push_data.last = 1'b0;
					do_shift       = 1'b1;
					do_emit        = 1'b1;
				end
			end
			ace_pkg::ST_FINISH: begin
				if (!hold_valid_q || out_free) begin
					push           = hold_valid_q;
					push_data.last = 1'b0;
					do_finish      = 1'b1;
					state_d        = ace_pkg::ST_FLUSH;
				end
			end
			ace_pkg::ST_FLUSH: begin
				if (!hold_valid_q) begin
					state_d = ace_pkg::ST_IDLE;
				end else if (out_free) begin
					push           = 1'b1;
					push_data.last = 1'b1;
					do_flush       = 1'b1;
					state_d        = ace_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ace_pkg::ST_IDLE;
			end
		endcase
	end

	// item latch
	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_q  <= kind;
			ch_q    <= ch_c;
			cl_q    <= cl_c;
			tot_q   <= tot_c;
			range_q <= {1'b0, high_q} - {1'b0, low_q} + QW'(1);
		end
		if (load_qh) begin
			qh_q <= md_quot;
		end
	end

	// coder state and hold slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q        <= '0;
			high_q       <= '1;
			pending_q    <= '0;
			steps_q      <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			if (load_narrow) begin
				low_q   <= low_narrow;
				high_q  <= high_narrow;
				steps_q <= '0;
			end else if (do_shift) begin
				// dropping the top bit removes the half; the middle case flips it back
				low_q   <= {low_q[CODE_BITS-2:0], 1'b0} ^ {do_mid, {(CODE_BITS-1){1'b0}}};
				high_q  <= {high_q[CODE_BITS-2:0], 1'b1} ^ {do_mid, {(CODE_BITS-1){1'b0}}};
				steps_q <= steps_q + STEP_W'(1);
			end else if (do_finish) begin
				low_q  <= '0;
				high_q <= '1;
			end
			if (do_mid) begin
				pending_q <= ace_pkg::follow_inc(pending_q);
			end else if (do_emit || do_finish) begin
				pending_q <= '0;
			end
			if (do_emit || do_finish) begin
				hold_valid_q <= 1'b1;
			end else if (do_flush) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			hold_q.out_bit      <= emit1;
			hold_q.follow_count <= pending_q;
			hold_q.last         <= 1'b0;
			hold_q.stream_end   <= 1'b0;
		end else if (do_finish) begin
			// closing bit picks the quarter that holds the interval
			hold_q.out_bit      <= low_q[CODE_BITS-1] | low_q[CODE_BITS-2];
			hold_q.follow_count <= ace_pkg::follow_inc(pending_q);
			hold_q.last         <= 1'b1;
			hold_q.stream_end   <= 1'b1;
		end
	end

	ace_out_stage u_out_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_data   (push_data),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_bit     (out_bit),
		.follow_count(follow_count),
		.last        (last),
		.stream_end  (stream_end)
	);

	assign in_ready = (state_q == ace_pkg::ST_IDLE);

endmodule

FILE: hw/rtl/ace_muldiv.sv
// ----------------------------------------------------------------------------
// ace_muldiv - shared scale unit: floor(a * b / div)
// One registered multiply, then a restoring divider retiring one quotient
// bit per cycle. The quotient must fit in QW bits (a*b < 2^QW * div).
// ----------------------------------------------------------------------------
module ace_muldiv #(
	parameter int QW = 17,
	parameter int FW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [QW-1:0] a,
	input  logic [FW-1:0] b,
	input  logic [FW-1:0] div,
	output logic          done,
	output logic [QW-1:0] quot
);

	localparam int PW    = QW + FW;
	localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

	logic [PW-1:0]    acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [FW:0]      trial;
	logic             ge;
	logic [FW:0]      diff;
	logic [FW-1:0]    rem_next;

	// partial remainder with the next dividend bit shifted in
	assign trial    = {acc_q[PW-1:QW], acc_q[QW-1]};
	assign ge       = trial >= {1'b0, div};
	assign diff     = trial - {1'b0, div};
	assign rem_next = ge ? diff[FW-1:0] : trial[FW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= PW'(a) * PW'(b);
		end else if (busy_q) begin
			acc_q <= {rem_next, acc_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = acc_q[QW-1:0];

endmodule

FILE: hw/rtl/ace_out_stage.sv
// ----------------------------------------------------------------------------
// ace_out_stage - result output register
// Holds one result until the consumer takes it; reports when it can load.
// ----------------------------------------------------------------------------
module ace_out_stage (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  ace_pkg::result_t                     push_data,
	output logic                                 free,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 out_bit,
	output logic [ace_pkg::FOLLOW_BITS-1:0]      follow_count,
	output logic                                 last,
	output logic                                 stream_end
);

	logic             valid_q;
	ace_pkg::result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign free         = !valid_q || out_ready;
	assign out_valid    = valid_q;
	assign out_bit      = data_q.out_bit;
	assign follow_count = data_q.follow_count;
	assign last         = data_q.last;
	assign stream_end   = data_q.stream_end;

endmodule

FILE: hw/rtl/ace_checker.sv
// ----------------------------------------------------------------------------
// ace_checker - port-level checks of the arithmetic encoder core
// Watches the top-level handshakes and result flags over time.
// ----------------------------------------------------------------------------
module ace_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            out_bit,
	input logic [ace_pkg::FOLLOW_BITS-1:0] follow_count,
	input logic                            last,
	input logic                            stream_end
);

	// one item in flight: accepting drops ready
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ace: in_ready still high after an input transfer");

	// a non-final result means its item is still in work
	a_not_ready_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("ace: input accepted while an item still has results to give");

	// the closing bit ends the item and carries at least one follow bit
	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> last && (follow_count != '0))
		else $error("ace: closing bit without last flag or follow bit");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
		&& $stable({out_bit, follow_count, last, stream_end}))
		else $error("ace: result changed or dropped while stalled");

endmodule

bind arithmetic_encoder_core ace_checker u_ace_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_bit     (out_bit),
	.follow_count(follow_count),
	.last        (last),
	.stream_end  (stream_end)
);
